// ===== rtl/fdl_pkg.sv =====
// Shared types and constants for the fractional delay line.
// Depends on nothing; every other file of the block but fdl_ram imports it.
package fdl_pkg;

   // Payload widths of the channels.
   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 28;
   localparam int FUNC_W   = 2;

   // Default store depth in samples.
   localparam int DEPTH_DEFAULT = 4096;

   // Fraction bits of the delay and width of the Q2.30 weights.
   localparam int FRAC_BITS = 16;
   localparam int COEF_W    = 32;

   // Exact floor(f / 3) for a 16-bit f is (f * THIRD_RECIP) >> THIRD_SHIFT.
   localparam logic [16:0] THIRD_RECIP = 17'd43691;
   localparam int          THIRD_SHIFT = 17;
   // (2^16 - 1) / 3, used to divide f - 2^16 and f + 2^16 by three.
   localparam int          THIRD_OF_ONE = 21845;

   // Cycles the weight and accumulate pipeline needs after the last tap fetch.
   localparam int CALC_CYCLES = 6;

   // Function codes of an input transaction.
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       wr_sample;
      logic       clr_ptr;
      logic       clr_wr;
      logic       ld_delay;
      logic       rd_en;
      logic [1:0] rd_idx;
      logic       ld_rsp;
   } fdl_cmd_type;

endpackage

// ===== rtl/fdl_ifs.sv =====
// Handshake channels of the fractional delay line: request and response.
// Depends on fdl_pkg for the payload widths.
interface fdl_req_if
   import fdl_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic        [FUNC_W-1:0]   func;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic        [DELAY_W-1:0]  delay;

   modport source (output valid, output func, output sample_in, output delay, input ready);
   modport sink   (input valid, input func, input sample_in, input delay, output ready);
endinterface

interface fdl_rsp_if
   import fdl_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/fdl_ram.sv =====
// Generic single-port RAM with a registered read.
// Depends on nothing.
module fdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access a cycle: write, or read with the data registered.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fdl_ctrl.sv =====
// Controller of the fractional delay line: sequences clears, writes and reads.
// Depends on fdl_pkg for the function codes and the command struct.
module fdl_ctrl
   import fdl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fdl_cmd_type              cmd,
   output logic [$clog2(DEPTH)-1:0] clr_addr
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [2:0]    CALC_LAST = 3'(CALC_CYCLES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_POS   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CALC  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]    tap_ff, tap_in;
   logic [2:0]    wait_ff, wait_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      tap_in     = tap_ff;
      wait_in    = wait_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_WRITE: begin
                     cmd.wr_sample = 1'b1;
                  end
                  FUNC_READ: begin
                     cmd.ld_delay = 1'b1;
                     state_in     = ST_POS;
                  end
                  FUNC_CLEAR: begin
                     cmd.clr_ptr = 1'b1;
                     clr_cnt_in  = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_POS: begin
            tap_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = tap_ff;
            if (tap_ff == 2'd3) begin
               wait_in  = '0;
               state_in = ST_CALC;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_CALC: begin
            if (wait_ff == CALC_LAST) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.ld_rsp = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result stays offered until the sink takes it.
   always_comb begin
      if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Reset starts a clearing pass over the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         tap_ff       <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         tap_ff       <= tap_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign clr_addr  = clr_cnt_ff;

endmodule

// ===== rtl/fdl_datapath.sv =====
// Datapath of the fractional delay line: pointer, sample store, tap fetch,
// Lagrange weight pipeline and multiply-accumulate. Depends on fdl_pkg and fdl_ram.
module fdl_datapath
   import fdl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fdl_cmd_type                cmd,
   input  logic [$clog2(DEPTH)-1:0]   clr_addr,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic [DELAY_W-1:0]         delay,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = ((AW + FRAC_BITS) > DELAY_W ? (AW + FRAC_BITS) : DELAY_W) + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [PW-1:0] SPAN     = PW'(DEPTH) << FRAC_BITS;
   localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;

   // Rounds n / 2^k to nearest with ties away from zero.
   function automatic logic signed [COEF_W-1:0] rnd_shr(input logic signed [54:0] n,
                                                        input int k);
      logic signed [54:0] half;
      logic signed [54:0] s;
      half = 55'sd1 <<< (k - 1);
      if (n < 0) begin
         half = half - 55'sd1;
      end
      s = (n + half) >>> k;
      return COEF_W'(s);
   endfunction

   logic [AW-1:0]             wi_ff, wi_in;
   logic [DELAY_W-1:0]        d_ff;
   logic [PW-1:0]             d_clamp, pos_raw, pos;
   logic [AW-1:0]             ip_ff;
   logic [FRAC_BITS-1:0]      f_ff;
   logic [AW-1:0]             ip_m1, ip_p1, ip_p2, tap_addr, ram_addr;
   logic                      ram_we;
   logic [SAMPLE_W-1:0]       ram_wdata, ram_rdata;
   logic                      rd_pend_ff;
   logic [1:0]                rd_idx_ff;
   logic signed [SAMPLE_W-1:0] tap_ff [4];

   // Write pointer: advances on a write, returns to zero on a clear.
   always_comb begin
      wi_in = wi_ff;
      if (cmd.clr_ptr) begin
         wi_in = '0;
      end else if (cmd.wr_sample) begin
         wi_in = (wi_ff == LAST_IDX) ? '0 : wi_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff      <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         wi_ff      <= wi_in;
         rd_pend_ff <= cmd.rd_en;
      end
   end

   // Read position: pointer - 1 - delay, wrapped into the store.
   always_comb begin
      d_clamp = (PW'(d_ff) >= SPAN) ? SPAN - ONE : PW'(d_ff);
      pos_raw = (PW'(wi_ff) << FRAC_BITS) + SPAN - ONE - d_clamp;
      pos     = (pos_raw >= SPAN) ? pos_raw - SPAN : pos_raw;
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_delay) begin
         d_ff <= delay;
      end
      ip_ff <= pos[AW+FRAC_BITS-1:FRAC_BITS];
      f_ff  <= pos[FRAC_BITS-1:0];
   end

   // Addresses of the four taps around the read position.
   always_comb begin
      ip_m1 = (ip_ff == '0) ? LAST_IDX : ip_ff - 1'b1;
      ip_p1 = (ip_ff == LAST_IDX) ? '0 : ip_ff + 1'b1;
      ip_p2 = (ip_p1 == LAST_IDX) ? '0 : ip_p1 + 1'b1;
      case (cmd.rd_idx)
         2'd0:    tap_addr = ip_m1;
         2'd1:    tap_addr = ip_ff;
         2'd2:    tap_addr = ip_p1;
         default: tap_addr = ip_p2;
      endcase
   end

   // The single memory port is shared by clearing, writes and tap fetches.
   always_comb begin
      ram_we    = cmd.wr_sample || cmd.clr_wr;
      ram_wdata = cmd.clr_wr ? '0 : sample_in;
      if (cmd.clr_wr) begin
         ram_addr = clr_addr;
      end else if (cmd.wr_sample) begin
         ram_addr = wi_ff;
      end else begin
         ram_addr = tap_addr;
      end
   end

   fdl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Capture each tap from the store's registered read data, with its index and read flag registered alongside.
   always_ff @(posedge clock) begin
      rd_idx_ff <= cmd.rd_idx;
      if (rd_pend_ff) begin
         tap_ff[rd_idx_ff] <= $signed(ram_rdata);
      end
   end

   // Weight stage 1: floor(f / 3).
   logic [32:0]          q3_prod;
   logic [15:0]          q3_ff;
   logic [FRAC_BITS-1:0] f1_ff;

   assign q3_prod = 33'(f_ff) * 33'(THIRD_RECIP);

   always_ff @(posedge clock) begin
      q3_ff <= q3_prod[THIRD_SHIFT+15:THIRD_SHIFT];
      f1_ff <= f_ff;
   end

   // Weight stage 2: the factors f, f-S, f-2S, f+S, with the one that
   // three divides already divided.
   logic [16:0]        rem_wide;
   logic [1:0]         rem3;
   logic signed [17:0] fa, fb, fc, fd, q3s;
   logic signed [17:0] w0a_in, w0b_in, w0t_in, w3a_in, w3b_in, w3t_in;
   logic signed [17:0] w0a_ff, w0b_ff, w0t_ff, w3a_ff, w3b_ff, w3t_ff;
   logic signed [17:0] fa_ff, fb_ff, fc_ff, fd_ff;

   always_comb begin
      rem_wide = 17'(f1_ff) - 17'(q3_ff) * 17'd3;
      rem3     = rem_wide[1:0];
      fa       = $signed(18'(f1_ff));
      fb       = fa - 18'sd65536;
      fc       = 18'(19'(fa) - 19'sd131072);
      fd       = fa + 18'sd65536;
      q3s      = $signed(18'(q3_ff));
      case (rem3)
         2'd0: begin
            w0t_in = q3s;                 w0a_in = fb; w0b_in = fc;
            w3t_in = q3s;                 w3a_in = fd; w3b_in = fb;
         end
         2'd1: begin
            w0t_in = q3s - 18'(THIRD_OF_ONE);     w0a_in = fa; w0b_in = fc;
            w3t_in = q3s - 18'(THIRD_OF_ONE);     w3a_in = fd; w3b_in = fa;
         end
         default: begin
            w0t_in = q3s - 18'(2 * THIRD_OF_ONE); w0a_in = fa; w0b_in = fb;
            w3t_in = q3s + 18'(THIRD_OF_ONE + 1); w3a_in = fa; w3b_in = fb;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      w0a_ff <= w0a_in;
      w0b_ff <= w0b_in;
      w0t_ff <= w0t_in;
      w3a_ff <= w3a_in;
      w3b_ff <= w3b_in;
      w3t_ff <= w3t_in;
      fa_ff  <= fa;
      fb_ff  <= fb;
      fc_ff  <= fc;
      fd_ff  <= fd;
   end

   // Weight stage 3: pair products.
   logic signed [35:0] pp_ff [4];
   logic signed [17:0] k_ff [4];

   always_ff @(posedge clock) begin
      pp_ff[0] <= 36'(w0a_ff) * 36'(w0b_ff);
      pp_ff[1] <= 36'(fd_ff) * 36'(fb_ff);
      pp_ff[2] <= 36'(fd_ff) * 36'(fa_ff);
      pp_ff[3] <= 36'(w3a_ff) * 36'(w3b_ff);
      k_ff[0]  <= w0t_ff;
      k_ff[1]  <= fc_ff;
      k_ff[2]  <= fc_ff;
      k_ff[3]  <= w3t_ff;
   end

   // Weight stage 4: triple products.
   logic signed [53:0] tr_ff [4];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         tr_ff[i] <= 54'(pp_ff[i]) * 54'(k_ff[i]);
      end
   end

   // Weight stage 5: round to Q2.30. The outer products already lost their factor
   // three, so what is left of each divisor, six or two, is a halving.
   logic signed [COEF_W-1:0] c_ff [4];

   always_ff @(posedge clock) begin
      c_ff[0] <= rnd_shr(-55'(tr_ff[0]), 19);
      c_ff[1] <= rnd_shr(55'(tr_ff[1]), 19);
      c_ff[2] <= rnd_shr(-55'(tr_ff[2]), 19);
      c_ff[3] <= rnd_shr(55'(tr_ff[3]), 19);
   end

   // Multiply-accumulate over the four taps.
   logic signed [55:0] prod_ff [4];
   logic signed [56:0] s01_ff, s23_ff;
   logic signed [57:0] acc_ff, acc_rnd;
   logic signed [SAMPLE_W-1:0] sat, y_ff, out_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= 56'(tap_ff[i]) * 56'(c_ff[i]);
      end
      s01_ff <= 57'(prod_ff[0]) + 57'(prod_ff[1]);
      s23_ff <= 57'(prod_ff[2]) + 57'(prod_ff[3]);
      acc_ff <= 58'(s01_ff) + 58'(s23_ff);
   end

   // Round to Q1.23, saturate, and bypass on a whole-sample delay.
   always_comb begin
      acc_rnd = (acc_ff + (58'sd1 <<< 29)) >>> 30;
      if (acc_rnd > 58'sd8388607) begin
         sat = 24'sh7FFFFF;
      end else if (acc_rnd < -58'sd8388608) begin
         sat = -24'sh800000;
      end else begin
         sat = SAMPLE_W'(acc_rnd);
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= (f_ff == '0) ? tap_ff[1] : sat;
      if (cmd.ld_rsp) begin
         out_ff <= y_ff;
      end
   end

   assign sample_out = out_ff;

endmodule

// ===== rtl/fractional_delay_line_lagrange.sv =====
// Fractional delay line with cubic Lagrange interpolation over a circular store of
// DEPTH Q1.23 samples. A write transaction is done in the cycle it is accepted, and an
// unused function code is dropped in that same cycle. A read transaction occupies the
// block from acceptance until its result is registered at the output: it forms the
// wrapped position, fetches the four taps in turn through the store's single port, and
// the weight and multiply-accumulate pipeline finishes the rest; the result is held
// until taken, and a new transaction is accepted meanwhile. A clear transaction,
// and likewise reset, runs a clearing pass over all DEPTH entries, one entry a cycle,
// during which no transaction is accepted.
// Depends on fdl_pkg, fdl_ifs, fdl_ctrl and fdl_datapath.
module fractional_delay_line_lagrange
   import fdl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   fdl_req_if.sink   req_chan,
   fdl_rsp_if.source rsp_chan
);

   fdl_cmd_type                cmd;
   logic [$clog2(DEPTH)-1:0]   clr_addr;

   fdl_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_func  (req_chan.func),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .clr_addr  (clr_addr)
   );

   fdl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .clr_addr   (clr_addr),
      .sample_in  (req_chan.sample_in),
      .delay      (req_chan.delay),
      .sample_out (rsp_chan.sample_out)
   );

endmodule
